// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq check failed");

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq check failed");

`endif

// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types, constants and helpers of the stable priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ID_W    = 16;
  localparam int PRI_W   = 4;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             op;
    logic [ID_W-1:0]  task_id;
    logic [PRI_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [ID_W-1:0]    out_task_id;
    logic [PRI_W-1:0]   out_priority;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic            load;
    logic            rd_head;
    logic            k_dec;
    logic            wr_shift;
    logic            wr_new;
    logic            push;
    logic            pop;
    logic            set_status;
    logic [ST_W-1:0] status;
    logic            take_head;
    logic            out_load;
  } spq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_remove;
    logic empty;
    logic full;
    logic k_zero;
    logic rd_ge;
  } spq_stat_t;

  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/spq_dp.sv =====
// ----------------------------------------------------------------------------
// spq_dp
// Entry memory as a ring (head pointer plus fill count), walk index,
// result staging and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_dp
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire spq_cmd_t  cmd,
  output spq_stat_t      stat,
  output out_item_t      out_data
);

  localparam logic [IDX_W:0] DEPTH_X = (IDX_W+1)'(DEPTH);

  entry_t mem [DEPTH];

  entry_t             rd_data_r;
  in_item_t           item_r;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [IDX_W-1:0]   head_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ST_W-1:0]    res_status_r;
  logic [ID_W-1:0]    res_id_r;
  logic [PRI_W-1:0]   res_pri_r;
  out_item_t          out_r;
  logic [IDX_W-1:0]   rd_k;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             new_entry;

  // logical slot to physical address, modulo depth
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[IDX_W-1:0];
  endfunction

  always_comb begin
    k_nxt = k_r;
    if (cmd.load) begin
      k_nxt = cnt_r[IDX_W-1:0];
    end else if (cmd.k_dec) begin
      k_nxt = k_r - IDX_W'(1);
    end
  end

  // prefetch the slot below the next walk position
  assign rd_k    = (k_nxt == '0) ? '0 : k_nxt - IDX_W'(1);
  assign rd_addr = cmd.rd_head ? head_r : wrap_add(head_r, rd_k);
  assign wr_addr = wrap_add(head_r, k_r);

  assign new_entry.pri = item_r.priority_req;
  assign new_entry.id  = item_r.task_id;

  always_ff @(posedge clk) begin
    if (cmd.wr_new || cmd.wr_shift) begin
      mem[wr_addr] <= cmd.wr_new ? new_entry : rd_data_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status;
      res_id_r     <= cmd.take_head ? rd_data_r.id  : '0;
      res_pri_r    <= cmd.take_head ? rd_data_r.pri : '0;
    end
    if (cmd.out_load) begin
      out_r.status       <= res_status_r;
      out_r.out_task_id  <= res_id_r;
      out_r.out_priority <= res_pri_r;
      out_r.count        <= to_count(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.pop) begin
      head_r <= wrap_add(head_r, IDX_W'(1));
      cnt_r  <= cnt_r - CNT_W'(1);
    end else if (cmd.push) begin
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

  assign stat.op_remove = (item_r.op == OP_REMOVE);
  assign stat.empty     = (cnt_r == '0);
  assign stat.full      = (cnt_r >= CNT_W'(DEPTH));
  assign stat.k_zero    = (k_r == '0);
  assign stat.rd_ge     = (rd_data_r.pri >= item_r.priority_req);

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== src/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for insert walks and removes, plus output valid handling.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire spq_stat_t stat,
  output spq_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_REM    = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.op_remove) begin
          if (stat.empty) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_EMPTY;
            state_nxt      = S_FIN;
          end else begin
            cmd.rd_head = 1'b1;
            state_nxt   = S_REM;
          end
        end else if (stat.full) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_REM: begin
        cmd.set_status = 1'b1;
        cmd.status     = ST_OK;
        cmd.take_head  = 1'b1;
        cmd.pop        = 1'b1;
        state_nxt      = S_FIN;
      end
      S_WALK: begin
        // stop above the first entry of equal or higher priority
        if (stat.k_zero || stat.rd_ge) begin
          cmd.wr_new     = 1'b1;
          cmd.push       = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
          state_nxt      = S_FIN;
        end else begin
          cmd.wr_shift = 1'b1;
          cmd.k_dec    = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue of tasks; equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries op, task_id and priority_req; a transfer happens when
//   in_valid is high and in_stall is low. op insert places the task after
//   every held task of equal or higher priority; op remove takes the head.
//   Every item gives one result on out_data: status (done, remove on empty,
//   insert on full dropped), the removed task's id and priority (zero
//   otherwise) and the count held afterwards.
//   A rejected item (remove on empty, insert on full) passes from the decide
//   state straight to the finish state, a remove goes through a head read
//   and a pop, and an insert walks down past each held task of lower
//   priority. The insert walk moves one entry per cycle through the entry
//   memory; items are handled one at a time and in_stall is high while busy,
//   so the next transfer comes at the earliest in the cycle in which
//   out_valid rises.
//   A finished result waits in the output register while the next item is
//   taken in; if out_stall holds, the block waits before its next result.
//   Reset (rst_n low, synchronous) empties the queue and drops any result.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== src/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spq_checker
  import spq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // a held result keeps its value
  `SPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // one item at a time: busy right after a transfer
  `SPQ_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)

  // a remove on empty leaves the queue empty and returns no task
  `SPQ_ASSERT_NOW(a_empty_result, out_valid && out_data.status == ST_EMPTY,
                  out_data.count == '0 && out_data.out_task_id == '0 &&
                  out_data.out_priority == '0)

  // a dropped insert returns no task
  `SPQ_ASSERT_NOW(a_full_result, out_valid && out_data.status == ST_FULL,
                  out_data.out_task_id == '0 && out_data.out_priority == '0)

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
